// File: rtl/core/sms_pkg.sv
// sms_pkg: shared types and sizing constants of the stable merge sorter
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package sms_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DEPTH     = 64;
  localparam int AW        = $clog2(DEPTH);
  localparam int CW        = AW + 1;
  localparam int DW        = 32;

  typedef logic signed [DW-1:0] data_t;
  typedef logic [CW-1:0]        cnt_t;
  typedef logic [AW-1:0]        addr_t;

endpackage

`default_nettype wire

// File: rtl/core/sms_if.sv
// sms_in_if / sms_out_if: valid/ready channels of the stable merge sorter
// depends on sms_pkg for the data type
`default_nettype none

interface sms_in_if import sms_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface sms_out_if import sms_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_result;
  logic  overflow;

  modport source (output valid, output sorted_value, output last_result,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/core/stable_merge_sorter.sv
// stable_merge_sorter: collects up to MAX_ITEMS signed values, then emits them
// in ascending stable order. Loading accepts one transaction per cycle. On the
// transaction marked last_item the block sorts with a bottom-up merge over two
// ping-pong buffers using one shared compare unit: ceil(log2(n)) passes for n
// held values, each setting up segments (S_SEG) and moving every element by a
// read (S_RD) and a compare (S_CMP). Results leave one at a time, read (S_ERD)
// and then put in the output register (S_EOUT) once it is free. Input is not
// taken during sort and emission; the block accepts the next set as soon as the
// final result sits in the output register. Values beyond capacity are dropped
// and every result of that set carries overflow. depends on sms_pkg and sms_if
`default_nettype none

module stable_merge_sorter import sms_pkg::*; (
  input  wire        clk,
  input  wire        rst_n,
  sms_in_if.sink     in_ch,
  sms_out_if.source  out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEG  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_ERD  = 3'd4;
  localparam logic [2:0] S_EOUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  cnt_t       n_r, n_nxt;
  logic       ovf_r, ovf_nxt;
  cnt_t       w_r, w_nxt;
  cnt_t       i_r, i_nxt, j_r, j_nxt, mid_r, mid_nxt, hi_r, hi_nxt, k_r, k_nxt;
  cnt_t       e_r, e_nxt;
  logic       src_r, src_nxt;

  logic       out_valid_r, out_valid_nxt;
  data_t      out_value_r, out_value_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_ovf_r, out_ovf_nxt;

  // ping-pong merge buffers
  data_t mem0 [DEPTH];
  data_t mem1 [DEPTH];
  data_t rd0a_r, rd0b_r, rd1a_r, rd1b_r;
  data_t rd_a, rd_b;
  addr_t ra_a, ra_b;
  logic  we0, we1;
  addr_t wa;
  data_t wd;

  logic       in_acc;
  logic       has_room;
  logic       take_left;
  logic [CW:0] seg_mid, seg_hi;
  cnt_t       w_dbl;
  cnt_t       load_n;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.sorted_value = out_value_r;
  assign out_ch.last_result  = out_last_r;
  assign out_ch.overflow     = out_ovf_r;

  assign in_acc   = in_ch.valid && (state_r == S_IDLE);
  assign has_room = (count_r < cnt_t'(MAX_ITEMS));
  assign load_n   = has_room ? count_r + cnt_t'(1) : count_r;

  assign ra_a = (state_r == S_ERD || state_r == S_EOUT) ? e_r[AW-1:0] : i_r[AW-1:0];
  assign ra_b = j_r[AW-1:0];
  assign rd_a = src_r ? rd1a_r : rd0a_r;
  assign rd_b = src_r ? rd1b_r : rd0b_r;

  // stable: ties go to the left run
  assign take_left = (i_r < mid_r) && ((j_r >= hi_r) || (rd_a <= rd_b));

  assign seg_mid = {1'b0, hi_r} + {1'b0, w_r};
  assign seg_hi  = {1'b0, hi_r} + {w_r, 1'b0};
  assign w_dbl   = {w_r[CW-2:0], 1'b0};

  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wa  = k_r[AW-1:0];
    wd  = take_left ? rd_a : rd_b;
    if (state_r == S_IDLE) begin
      we0 = in_acc && has_room;
      wa  = count_r[AW-1:0];
      wd  = in_ch.value;
    end else if (state_r == S_CMP) begin
      we0 = src_r;
      we1 = !src_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa] <= wd;
    end
    rd0a_r <= mem0[ra_a];
    rd0b_r <= mem0[ra_b];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa] <= wd;
    end
    rd1a_r <= mem1[ra_a];
    rd1b_r <= mem1[ra_b];
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    w_nxt         = w_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    k_nxt         = k_r;
    e_nxt         = e_r;
    src_nxt       = src_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          count_nxt = load_n;
          if (!has_room) begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_item) begin
            n_nxt   = load_n;
            src_nxt = 1'b0;
            w_nxt   = cnt_t'(1);
            hi_nxt  = '0;
            k_nxt   = '0;
            e_nxt   = '0;
            state_nxt = (load_n > cnt_t'(1)) ? S_SEG : S_ERD;
          end
        end
      end
      S_SEG: begin
        // next segment starts where the previous one ended
        i_nxt   = hi_r;
        mid_nxt = (seg_mid > {1'b0, n_r}) ? n_r : seg_mid[CW-1:0];
        j_nxt   = (seg_mid > {1'b0, n_r}) ? n_r : seg_mid[CW-1:0];
        hi_nxt  = (seg_hi > {1'b0, n_r}) ? n_r : seg_hi[CW-1:0];
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (take_left) begin
          i_nxt = i_r + cnt_t'(1);
        end else begin
          j_nxt = j_r + cnt_t'(1);
        end
        k_nxt = k_r + cnt_t'(1);
        if (k_r + cnt_t'(1) == hi_r) begin
          if (hi_r == n_r) begin
            src_nxt = !src_r;
            w_nxt   = w_dbl;
            hi_nxt  = '0;
            k_nxt   = '0;
            e_nxt   = '0;
            state_nxt = (w_dbl >= n_r) ? S_ERD : S_SEG;
          end else begin
            state_nxt = S_SEG;
          end
        end else begin
          state_nxt = S_RD;
        end
      end
      S_ERD: begin
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = rd_a;
          out_last_nxt  = (e_r + cnt_t'(1) == n_r);
          out_ovf_nxt   = ovf_r;
          if (e_r + cnt_t'(1) == n_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = e_r + cnt_t'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      src_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      src_r       <= src_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    w_r         <= w_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    mid_r       <= mid_nxt;
    hi_r        <= hi_nxt;
    k_r         <= k_nxt;
    e_r         <= e_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_ITEMS))
    else $error("item count above capacity");

  a_merge_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> (i_r < mid_r) || (j_r < hi_r))
    else $error("merge step with both runs exhausted");

  a_width_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEG || state_r == S_RD || state_r == S_CMP) |-> $onehot(w_r))
    else $error("merge run width not a power of two");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERD || state_r == S_EOUT) |-> e_r < n_r)
    else $error("emit index past run length");

endmodule

`default_nettype wire

// File: tb/tb_stable_merge_sorter.sv
// tb_stable_merge_sorter: self-checking testbench for the stable merge sorter
// depends on sms_pkg, the sms_in_if / sms_out_if channels and stable_merge_sorter
`timescale 1ns / 100ps

module tb_stable_merge_sorter import sms_pkg::*;;

  localparam data_t VAL_MIN      = 32'sh8000_0000;
  localparam data_t VAL_MAX      = 32'sh7fff_ffff;
  localparam int    IDLE_LIMIT   = 5000;
  localparam int    DRAIN_CYCLES = 50;
  localparam int    RANDOM_ITEMS = 16;

  typedef enum int {FILL_FULL, FILL_NARROW, FILL_EXTREME, FILL_RISING} fill_t;

  typedef struct {
    data_t sorted_value;
    logic  last_result;
    logic  overflow;
  } sorted_item_t;

  logic clk;
  logic rst_n;

  sms_in_if  in_ch ();
  sms_out_if out_ch ();

  stable_merge_sorter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  data_t        held_values[$];
  bit           set_dropped;
  sorted_item_t pending_results[$];

  int unsigned values_sent;
  int unsigned sets_sorted;
  int unsigned results_checked;
  int unsigned mismatches;
  int unsigned idle_cycles;

  // idling controls
  bit          tx_idle_en;
  bit          rx_stall_en;
  bit          rx_hold_req;
  int unsigned rx_hold_len;

  sorted_item_t got_item;
  sorted_item_t want_item;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // hold values up to capacity, then on last a stable ascending sort into expected results
  function automatic void load_value(data_t v, bit last);
    data_t run[$];
    data_t key;
    int    j;
    int    n;
    values_sent++;
    if (held_values.size() < MAX_ITEMS) held_values.push_back(v);
    else set_dropped = 1'b1;
    if (!last) return;
    run = held_values;
    n = run.size();
    for (int i = 1; i < n; i++) begin
      key = run[i];
      j = i - 1;
      while (j >= 0 && run[j] > key) begin
        run[j + 1] = run[j];
        j--;
      end
      run[j + 1] = key;
    end
    for (int k = 0; k < n; k++) begin
      pending_results.push_back('{run[k], (k == n - 1), set_dropped});
    end
    held_values.delete();
    set_dropped = 1'b0;
    sets_sorted++;
  endfunction

  task automatic send_item(input data_t v, input bit last);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.last_item <= last;
    do @(posedge clk); while (!in_ch.ready);
    load_value(v, last);
  endtask

  task automatic send_set(input data_t vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  function automatic data_t pick_value(fill_t fill, int idx);
    case (fill)
      FILL_NARROW:  return data_t'(int'($urandom_range(0, 6)) - 3);
      FILL_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return data_t'(-1);
          default: return data_t'(0);
        endcase
      end
      FILL_RISING:  return data_t'(idx * 4 + int'($urandom_range(0, 5)) - 100);
      default:      return data_t'($urandom);
    endcase
  endfunction

  task automatic send_random_set(input int n, input fill_t fill);
    for (int i = 0; i < n; i++) send_item(pick_value(fill, i), i == n - 1);
  endtask

  task automatic test_extremes;
    send_set({VAL_MIN});
    send_set({VAL_MAX});
    send_set({VAL_MAX, VAL_MIN, data_t'(0), data_t'(-1), data_t'(1), VAL_MAX, VAL_MIN});
  endtask

  task automatic test_ordering;
    // equal keys, presorted and reversed input
    send_set({data_t'(5), data_t'(5), data_t'(-5), data_t'(5), data_t'(-5)});
    send_set({data_t'(-2), data_t'(0), data_t'(3), data_t'(9)});
    send_set({data_t'(9), data_t'(3), data_t'(0), data_t'(-2)});
  endtask

  task automatic test_capacity;
    // exactly full with last stored, then a set whose tail and last are dropped
    send_random_set(MAX_ITEMS, FILL_FULL);
    send_random_set(MAX_ITEMS + 3, FILL_NARROW);
  endtask

  task automatic test_random_sets;
    int    sent;
    int    n;
    fill_t fill;
    sent = 0;
    tx_idle_en  = 1'b1;
    rx_stall_en = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0:       n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
        1, 2:    n = $urandom_range(13, MAX_ITEMS);
        default: n = $urandom_range(1, 12);
      endcase
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      fill = fill_t'($urandom_range(0, 3));
      send_random_set(n, fill);
      sent += n;
    end
  endtask

  task automatic test_backpressure;
    // receiver holds off long enough that the sorter stops taking input
    rx_hold_len = 600;
    rx_hold_req = 1'b1;
    send_random_set(6, FILL_FULL);
    send_random_set(5, FILL_NARROW);
    send_random_set(3, FILL_EXTREME);
  endtask

  task automatic test_streaming;
    tx_idle_en  = 1'b0;
    rx_stall_en = 1'b0;
    for (int s = 0; s < 3; s++) begin
      send_random_set($urandom_range(1, 5), fill_t'($urandom_range(0, 3)));
    end
  endtask

  // receiver: random stall bursts and the long hold-off
  initial begin
    int unsigned len;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        len = rx_hold_len;
        rx_hold_req = 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        len = $urandom_range(1, 12);
      end else begin
        out_ch.ready <= 1'b1;
        len = rx_stall_en ? $urandom_range(1, 8) : 1;
      end
      repeat (len) @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_item = '{out_ch.sorted_value, out_ch.last_result, out_ch.overflow};
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d last %0b overflow %0b",
                   got_item.sorted_value, got_item.last_result, got_item.overflow);
      end else begin
        want_item = pending_results.pop_front();
        if (got_item.sorted_value !== want_item.sorted_value ||
            got_item.last_result !== want_item.last_result ||
            got_item.overflow !== want_item.overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d last %0b ovf %0b, got %0d last %0b ovf %0b",
                     want_item.sorted_value, want_item.last_result, want_item.overflow,
                     got_item.sorted_value, got_item.last_result, got_item.overflow);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.last_item <= 1'b0;
    tx_idle_en      = 1'b0;
    rx_stall_en     = 1'b0;
    rx_hold_req     = 1'b0;
    rx_hold_len     = 0;
    set_dropped     = 1'b0;
    values_sent     = 0;
    sets_sorted     = 0;
    results_checked = 0;
    mismatches      = 0;
    idle_cycles     = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_ordering();
    test_capacity();
    test_random_sets();
    test_backpressure();
    test_streaming();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (held_values.size() != 0) $display("note: %0d values left unsorted", held_values.size());
    $display("run covered %0d values in %0d sets, %0d sorted results compared",
             values_sent, sets_sorted, results_checked);
    $display("sets included single values, extremes, duplicates, full and overflowing buffers");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: stable_merge_sorter.f
rtl/core/sms_pkg.sv
rtl/core/sms_if.sv
rtl/core/stable_merge_sorter.sv
tb/tb_stable_merge_sorter.sv
